// File: rtl/gsp_pkg.sv
// Package for the grain sample player: codes, field widths and parameter defaults.
`default_nettype none
package gsp_pkg;

	localparam int DEF_SAMPLE_DEPTH   = 4096;
	localparam int DEF_ENVELOPE_DEPTH = 1024;
	localparam int DEF_MAX_CHANNELS   = 8;
	localparam int DEF_SAMPLE_WIDTH   = 16;

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 12;
	localparam int VALUE_W  = 16;
	localparam int OUT_W    = 16;
	localparam int ENVPOS_W = 10;
	localparam int GAIN_W   = 15;

	localparam int NCH_W   = 4;
	localparam int SRCL_W  = 13;
	localparam int ENVL_W  = 11;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 13;
	localparam int FRAME_W = 13;

	localparam logic [CMD_W-1:0] CMD_LOAD_SAMPLE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_ENVELOPE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ACTIVATE      = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK          = 2'd3;

	localparam logic [CFGI_W-1:0] REG_NUM_CHANNELS    = 2'd0;
	localparam logic [CFGI_W-1:0] REG_SOURCE_LENGTH   = 2'd1;
	localparam logic [CFGI_W-1:0] REG_ENVELOPE_LENGTH = 2'd2;

	localparam logic [NCH_W-1:0]  RST_NUM_CHANNELS    = 4'd1;
	localparam logic [SRCL_W-1:0] RST_SOURCE_LENGTH   = 13'd4096;
	localparam logic [ENVL_W-1:0] RST_ENVELOPE_LENGTH = 11'd1024;

endpackage
`default_nettype wire

// File: rtl/gsp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none
module gsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/grain_sample_player.sv
// Grain sample player top level: command decode, playback counters, stores and gain stage.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  command, address, value, backwards, loop
//  out      output     out_valid / out_stall sample_out, completed, to_remove, envelope_position
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low. A tick's result passes through
// the store read register, then the gain multiply into the output register.
// Counters and flags update as the tick is taken, so the next tick follows at once.
// Reset clears counters, flags and valid bits and loads the config defaults; stores and data registers are not cleared.
// A stalled output holds the pipeline; the input stalls only when both stages are full.
`default_nettype none
module grain_sample_player #(
	parameter int SAMPLE_DEPTH   = gsp_pkg::DEF_SAMPLE_DEPTH,
	parameter int ENVELOPE_DEPTH = gsp_pkg::DEF_ENVELOPE_DEPTH,
	parameter int MAX_CHANNELS   = gsp_pkg::DEF_MAX_CHANNELS,
	parameter int SAMPLE_WIDTH   = gsp_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [gsp_pkg::CMD_W-1:0]    command,
	input  wire logic        [gsp_pkg::ADDR_W-1:0]   address,
	input  wire logic signed [gsp_pkg::VALUE_W-1:0]  value,
	input  wire logic                                backwards,
	input  wire logic                                loop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [gsp_pkg::OUT_W-1:0]    sample_out,
	output logic                                     completed,
	output logic                                     to_remove,
	output logic             [gsp_pkg::ENVPOS_W-1:0] envelope_position,
	input  wire logic                                cfg_we,
	input  wire logic        [gsp_pkg::CFGI_W-1:0]   cfg_index,
	input  wire logic        [gsp_pkg::CFGD_W-1:0]   cfg_data
);
	import gsp_pkg::*;

	localparam int SA_W  = $clog2(SAMPLE_DEPTH);
	localparam int EA_W  = $clog2(ENVELOPE_DEPTH);
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int POS_W = FRAME_W + NCH_W + 1;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int PW    = SW + GAIN_W + 1;

	logic [NCH_W-1:0]  nch_q;
	logic [SRCL_W-1:0] srcl_q;
	logic [ENVL_W-1:0] envl_q;

	logic [FRAME_W-1:0] frame_q;
	logic [CH_W-1:0]    chan_q;
	logic [EA_W-1:0]    env_q;
	logic               reverse_q;
	logic               done_q;
	logic               remove_q;

	logic              s1_valid_s1;
	logic              s1_play_s1;
	logic              s1_done_s1;
	logic              s1_remove_s1;
	logic [EA_W-1:0]   s1_env_s1;

	logic signed [OUT_W-1:0]    sample_q;
	logic                       out_valid_q;
	logic                       completed_q;
	logic                       remove_out_q;
	logic [ENVPOS_W-1:0]        envpos_q;

	logic s1_adv, s1_load, in_fire, is_tick;

	logic [NCH_W-1:0]  nc;
	logic [SRCL_W-1:0] srcs;
	logic [ENVL_W-1:0] elen;
	logic [POS_W-1:0]  pos, pos_eff, idx;
	logic              at_end, wrap, finish;
	logic [FRAME_W-1:0] frame_eff, frame_nxt;
	logic [CH_W-1:0]   chan_eff, chan_nxt;
	logic [CH_W:0]     chan_inc;
	logic [EA_W-1:0]   env_cur, env_nxt;
	logic [EA_W:0]     env_inc;

	logic              samp_we, env_we;
	logic [SW-1:0]     samp_rd;
	logic [GAIN_W-1:0] gain_rd;

	logic signed [PW-1:0]        prod;
	logic signed [PW-GAIN_W-1:0] shifted;
	logic signed [47:0]          shifted_ext;
	logic signed [OUT_W-1:0]     scaled;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_load  = !s1_valid_s1 || s1_adv;
	assign in_stall = !s1_load;
	assign in_fire  = in_valid && s1_load;
	assign is_tick  = in_fire && (command == CMD_TICK);

	always_comb begin
		nc = nch_q;
		if (nch_q == '0) begin
			nc = NCH_W'(1);
		end else if (32'(nch_q) > MAX_CHANNELS) begin
			nc = NCH_W'(MAX_CHANNELS);
		end
		srcs = srcl_q;
		if (srcl_q == '0) begin
			srcs = SRCL_W'(1);
		end else if (32'(srcl_q) > SAMPLE_DEPTH) begin
			srcs = SRCL_W'(SAMPLE_DEPTH);
		end
		elen = envl_q;
		if (envl_q == '0) begin
			elen = ENVL_W'(1);
		end else if (32'(envl_q) > ENVELOPE_DEPTH) begin
			elen = ENVL_W'(ENVELOPE_DEPTH);
		end
	end

	always_comb begin
		pos    = POS_W'(frame_q) * POS_W'(nc) + POS_W'(chan_q);
		at_end = pos >= POS_W'(srcs);
		wrap   = at_end && loop;
		finish = at_end && !loop;

		pos_eff   = wrap ? '0 : pos;
		frame_eff = wrap ? '0 : frame_q;
		chan_eff  = wrap ? '0 : chan_q;

		idx = reverse_q ? (POS_W'(srcs) - POS_W'(1) - pos_eff) : pos_eff;

		chan_inc = (CH_W + 1)'(chan_eff) + (CH_W + 1)'(1);
		if (32'(chan_inc) >= 32'(nc)) begin
			chan_nxt  = '0;
			frame_nxt = frame_eff + FRAME_W'(1);
		end else begin
			chan_nxt  = CH_W'(chan_inc);
			frame_nxt = frame_eff;
		end

		env_cur = (32'(env_q) >= 32'(elen)) ? '0 : env_q;
		env_inc = (EA_W + 1)'(env_cur) + (EA_W + 1)'(1);
		env_nxt = (32'(env_inc) >= 32'(elen)) ? '0 : EA_W'(env_inc);
	end

	assign samp_we = in_fire && (command == CMD_LOAD_SAMPLE) && (32'(address) < SAMPLE_DEPTH);
	assign env_we  = in_fire && (command == CMD_LOAD_ENVELOPE) &&
		(32'(address) < ENVELOPE_DEPTH);

	gsp_ram #(
		.WIDTH(SW),
		.DEPTH(SAMPLE_DEPTH)
	) u_sample_ram (
		.clk  (clk),
		.we   (samp_we),
		.waddr(SA_W'(address)),
		.wdata(SW'(value)),
		.re   (is_tick && !finish),
		.raddr(SA_W'(idx)),
		.rdata(samp_rd)
	);

	gsp_ram #(
		.WIDTH(GAIN_W),
		.DEPTH(ENVELOPE_DEPTH)
	) u_envelope_ram (
		.clk  (clk),
		.we   (env_we),
		.waddr(EA_W'(address)),
		.wdata(value[GAIN_W-1:0]),
		.re   (is_tick && !finish),
		.raddr(env_cur),
		.rdata(gain_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q  <= RST_NUM_CHANNELS;
			srcl_q <= RST_SOURCE_LENGTH;
			envl_q <= RST_ENVELOPE_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_CHANNELS:    nch_q  <= cfg_data[NCH_W-1:0];
				REG_SOURCE_LENGTH:   srcl_q <= cfg_data[SRCL_W-1:0];
				REG_ENVELOPE_LENGTH: envl_q <= cfg_data[ENVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			chan_q    <= '0;
			env_q     <= '0;
			reverse_q <= 1'b0;
			done_q    <= 1'b0;
			remove_q  <= 1'b0;
		end else if (in_fire && command == CMD_ACTIVATE) begin
			frame_q   <= '0;
			chan_q    <= '0;
			reverse_q <= backwards;
			done_q    <= 1'b0;
		end else if (is_tick) begin
			if (finish) begin
				done_q   <= 1'b1;
				remove_q <= 1'b1;
			end else begin
				frame_q <= frame_nxt;
				chan_q  <= chan_nxt;
				env_q   <= env_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_load) begin
			s1_valid_s1 <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			s1_play_s1   <= !finish;
			s1_done_s1   <= done_q || finish;
			s1_remove_s1 <= remove_q || finish;
			s1_env_s1    <= finish ? env_q : env_nxt;
		end
	end

	always_comb begin
		prod        = $signed(samp_rd) * $signed({1'b0, gain_rd});
		shifted     = (PW - GAIN_W)'(prod >>> GAIN_W);
		shifted_ext = 48'(shifted);
		if (shifted_ext > 48'sd32767) begin
			scaled = 16'sh7fff;
		end else if (shifted_ext < -48'sd32768) begin
			scaled = 16'sh8000;
		end else begin
			scaled = OUT_W'(shifted_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			sample_q     <= s1_play_s1 ? scaled : '0;
			completed_q  <= s1_done_s1;
			remove_out_q <= s1_remove_s1;
			envpos_q     <= ENVPOS_W'(s1_env_s1);
		end
	end

	assign out_valid         = out_valid_q;
	assign sample_out        = sample_q;
	assign completed         = completed_q;
	assign to_remove         = remove_out_q;
	assign envelope_position = envpos_q;

endmodule
`default_nettype wire
